// ===== hw/rtl/sbfd_pkg.sv =====
`default_nettype none

package sbfd_pkg;

   localparam int HEADER_BYTES = 10;
   localparam int VALUE_WIDTH  = 64;
   localparam int MAX_FIELDS   = 1024;

   localparam int INDEX_WIDTH     = 10;
   localparam int FIELD_NUM_WIDTH = ($clog2(MAX_FIELDS) > INDEX_WIDTH) ?
                                    $clog2(MAX_FIELDS) : INDEX_WIDTH;

   typedef enum logic [2:0] {
      KIND_HEADER    = 3'd0,
      KIND_PMAP      = 3'd1,
      KIND_TEMPLATE  = 3'd2,
      KIND_FIELD     = 3'd3,
      KIND_TRUNCATED = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      logic [63:0]              value;
      logic [INDEX_WIDTH-1:0]   field_index;
      logic [3:0]               byte_count;
      logic                     overflow;
      logic [15:0]              chunk_count;
      logic [15:0]              chunk_number;
      logic [15:0]              body_length;
      logic                     template_present;
      logic                     message_end;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sbfd_core.sv =====
`default_nettype none

module sbfd_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         data_byte,
   output logic                    result_valid,
   output sbfd_pkg::result_type    result
);
   import sbfd_pkg::*;

   localparam logic [3:0] SEQ_END   = 4'd4;
   localparam logic [3:0] COUNT_END = 4'd6;
   localparam logic [3:0] CNUM_END  = 4'd8;
   localparam logic [3:0] HDR_LAST  = 4'(HEADER_BYTES - 1);
   localparam logic [FIELD_NUM_WIDTH-1:0] FIELD_LAST = FIELD_NUM_WIDTH'(MAX_FIELDS - 1);

   logic                       in_body_ff, in_body_in;
   logic [3:0]                 header_position_ff, header_position_in;
   logic [31:0]                sequence_number_ff, sequence_number_in;
   logic [15:0]                chunks_total_ff, chunks_total_in;
   logic [15:0]                chunk_current_ff, chunk_current_in;
   logic [15:0]                bytes_remaining_ff, bytes_remaining_in;
   logic [VALUE_WIDTH-1:0]     accumulator_ff, accumulator_in;
   logic [3:0]                 field_bytes_ff, field_bytes_in;
   logic [FIELD_NUM_WIDTH-1:0] field_number_ff, field_number_in;
   logic                       overflow_seen_ff, overflow_seen_in;
   logic                       template_expected_ff, template_expected_in;
   logic                       stop_bit;
   logic                       body_end;

   always_comb begin
      in_body_in           = in_body_ff;
      header_position_in   = header_position_ff;
      sequence_number_in   = sequence_number_ff;
      chunks_total_in      = chunks_total_ff;
      chunk_current_in     = chunk_current_ff;
      bytes_remaining_in   = bytes_remaining_ff;
      accumulator_in       = accumulator_ff;
      field_bytes_in       = field_bytes_ff;
      field_number_in      = field_number_ff;
      overflow_seen_in     = overflow_seen_ff;
      template_expected_in = template_expected_ff;
      stop_bit             = data_byte[7];
      body_end             = 1'b0;
      result_valid         = 1'b0;
      result               = '0;

      if (accept) begin
         if (!in_body_ff) begin
            if (header_position_ff < SEQ_END) begin
               sequence_number_in = {sequence_number_ff[23:0], data_byte};
            end else if (header_position_ff < COUNT_END) begin
               chunks_total_in = {chunks_total_ff[7:0], data_byte};
            end else if (header_position_ff < CNUM_END) begin
               chunk_current_in = {chunk_current_ff[7:0], data_byte};
            end else begin
               bytes_remaining_in = {bytes_remaining_ff[7:0], data_byte};
            end

            if (header_position_ff != HDR_LAST) begin
               header_position_in = header_position_ff + 4'd1;
            end else begin
               header_position_in      = '0;
               accumulator_in          = '0;
               field_bytes_in          = '0;
               field_number_in         = '0;
               overflow_seen_in        = 1'b0;
               template_expected_in    = 1'b0;
               in_body_in              = (bytes_remaining_in != 16'd0);
               result_valid            = 1'b1;
               result.kind             = KIND_HEADER;
               result.value            = 64'(sequence_number_in);
               result.byte_count       = 4'(HEADER_BYTES);
               result.chunk_count      = chunks_total_in;
               result.chunk_number     = chunk_current_in;
               result.body_length      = bytes_remaining_in;
               result.message_end      = (bytes_remaining_in == 16'd0);
            end
         end else begin
            if (field_number_ff == '0 && field_bytes_ff == 4'd0) begin
               template_expected_in = data_byte[6];
            end
            overflow_seen_in = overflow_seen_ff ||
                               (accumulator_ff[VALUE_WIDTH-1 -: 7] != 7'd0);
            accumulator_in   = {accumulator_ff[VALUE_WIDTH-8:0], data_byte[6:0]};
            if (field_bytes_ff != 4'd15) begin
               field_bytes_in = field_bytes_ff + 4'd1;
            end
            bytes_remaining_in = bytes_remaining_ff - 16'd1;
            body_end           = (bytes_remaining_in == 16'd0);

            if (stop_bit || body_end) begin
               result_valid            = 1'b1;
               result.value            = 64'(accumulator_in);
               result.field_index      = field_number_ff[INDEX_WIDTH-1:0];
               result.byte_count       = field_bytes_in;
               result.overflow         = overflow_seen_in;
               result.template_present = template_expected_in;
               result.message_end      = body_end;
               if (!stop_bit) begin
                  result.kind = KIND_TRUNCATED;
               end else if (field_number_ff == '0) begin
                  result.kind = KIND_PMAP;
               end else if (field_number_ff == FIELD_NUM_WIDTH'(1) &&
                            template_expected_in) begin
                  result.kind = KIND_TEMPLATE;
               end else begin
                  result.kind = KIND_FIELD;
               end

               accumulator_in   = '0;
               field_bytes_in   = '0;
               overflow_seen_in = 1'b0;
               if (body_end) begin
                  in_body_in           = 1'b0;
                  header_position_in   = '0;
                  field_number_in      = '0;
                  template_expected_in = 1'b0;
               end else if (field_number_ff != FIELD_LAST) begin
                  field_number_in = field_number_ff + FIELD_NUM_WIDTH'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff           <= 1'b0;
         header_position_ff   <= '0;
         sequence_number_ff   <= '0;
         chunks_total_ff      <= '0;
         chunk_current_ff     <= '0;
         bytes_remaining_ff   <= '0;
         accumulator_ff       <= '0;
         field_bytes_ff       <= '0;
         field_number_ff      <= '0;
         overflow_seen_ff     <= 1'b0;
         template_expected_ff <= 1'b0;
      end else begin
         in_body_ff           <= in_body_in;
         header_position_ff   <= header_position_in;
         sequence_number_ff   <= sequence_number_in;
         chunks_total_ff      <= chunks_total_in;
         chunk_current_ff     <= chunk_current_in;
         bytes_remaining_ff   <= bytes_remaining_in;
         accumulator_ff       <= accumulator_in;
         field_bytes_ff       <= field_bytes_in;
         field_number_ff      <= field_number_in;
         overflow_seen_ff     <= overflow_seen_in;
         template_expected_ff <= template_expected_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/stop_bit_message_field_decoder.sv =====
// Decodes a stream of framed messages, one byte per transfer: a ten-byte
// big-endian header (sequence number, chunk count, chunk number, body length)
// followed by a body of stop-bit fields, where bit 7 closes a field. Each
// header and each field gives one result; bytes that do not close anything
// give none. A byte is taken every cycle while req_stall is low; unless the
// output is stalled, its result reaches the rsp_ side the cycle after it is
// accepted, as the whole decode of a byte is one pass of combinational logic
// from the message state registers into the result register. A second one
// catches a stalled result, so req_stall rises only when both are full.
`default_nettype none

module stop_bit_message_field_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [63:0]      rsp_value,
   output logic [9:0]       rsp_field_index,
   output logic [3:0]       rsp_byte_count,
   output logic             rsp_overflow,
   output logic [15:0]      rsp_chunk_count,
   output logic [15:0]      rsp_chunk_number,
   output logic [15:0]      rsp_body_length,
   output logic             rsp_template_present,
   output logic             rsp_message_end
);
   import sbfd_pkg::*;

   logic       accept;
   logic       core_valid;
   result_type core_result;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   assign accept = req_valid && !skid_valid_ff;

   sbfd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .result_valid (core_valid),
      .result       (core_result)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_in = core_valid;
         out_in       = core_result;
      end else if (core_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall            = skid_valid_ff;
   assign rsp_valid            = out_valid_ff;
   assign rsp_kind             = 3'(out_ff.kind);
   assign rsp_value            = out_ff.value;
   assign rsp_field_index      = out_ff.field_index;
   assign rsp_byte_count       = out_ff.byte_count;
   assign rsp_overflow         = out_ff.overflow;
   assign rsp_chunk_count      = out_ff.chunk_count;
   assign rsp_chunk_number     = out_ff.chunk_number;
   assign rsp_body_length      = out_ff.body_length;
   assign rsp_template_present = out_ff.template_present;
   assign rsp_message_end      = out_ff.message_end;

endmodule

`default_nettype wire

// ===== hw/rtl/sbfd_checker.sv =====
`default_nettype none

module sbfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_kind,
   input wire logic [63:0] rsp_value,
   input wire logic [9:0]  rsp_field_index,
   input wire logic [3:0]  rsp_byte_count,
   input wire logic        rsp_overflow,
   input wire logic [15:0] rsp_chunk_count,
   input wire logic [15:0] rsp_chunk_number,
   input wire logic [15:0] rsp_body_length,
   input wire logic        rsp_template_present,
   input wire logic        rsp_message_end
);
   import sbfd_pkg::*;

   logic is_header;

   assign is_header = (rsp_kind == 3'(KIND_HEADER));

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) &&
                                 $stable(rsp_kind))
      else $error("A stalled result changed.");

   a_header_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_header |-> rsp_byte_count == 4'(HEADER_BYTES) &&
                                 !rsp_overflow && !rsp_template_present &&
                                 rsp_field_index == 10'd0 &&
                                 rsp_message_end == (rsp_body_length == 16'd0))
      else $error("A header result carries inconsistent fields.");

   a_field_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_header |-> rsp_chunk_count == 16'd0 &&
                                  rsp_chunk_number == 16'd0 &&
                                  rsp_body_length == 16'd0 &&
                                  rsp_byte_count != 4'd0)
      else $error("A field result carries header values.");

   a_truncated_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 3'(KIND_TRUNCATED) |-> rsp_message_end)
      else $error("A truncated field did not close its message.");

   a_template_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == 3'(KIND_TEMPLATE) |->
         rsp_template_present && rsp_field_index == 10'd1)
      else $error("A template id appeared without its presence bit.");

endmodule

bind stop_bit_message_field_decoder sbfd_checker u_sbfd_checker (.*);

`default_nettype wire
